/* design/lfpd_pkg.sv */
// Shared definitions for the line-follower PID motor drive.
// Field widths, configuration and pipeline control types, width helpers.
// Depends on nothing; every other design file imports it.
package lfpd_pkg;

    localparam int IN_W       = 4;
    localparam int DUTY_OUT_W = 10;
    localparam int ERR_W      = 10;
    localparam int GAIN_W     = 16;
    localparam int BASE_W     = 10;
    localparam int TRIM_W     = 11;
    localparam int SETTLE_W   = 16;
    localparam int TABLE_W    = 60;
    localparam int CNT_W      = 3;
    localparam int FRAC_BITS  = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 60;

    localparam int DEF_MAX_DUTY  = 1000;
    localparam int DEF_SUM_LIMIT = 100;

    localparam logic signed [GAIN_W-1:0]   RST_GAIN_P   = 16'sd256;
    localparam logic signed [GAIN_W-1:0]   RST_GAIN_I   = 16'sd0;
    localparam logic signed [GAIN_W-1:0]   RST_GAIN_D   = 16'sd0;
    localparam logic        [BASE_W-1:0]   RST_BASE     = 10'd500;
    localparam logic signed [TRIM_W-1:0]   RST_TRIM     = 11'sd0;
    localparam logic        [SETTLE_W-1:0] RST_SETTLE   = 16'd0;
    localparam logic        [TABLE_W-1:0]  RST_TABLE    = 60'd0;

    typedef struct packed {
        logic signed [GAIN_W-1:0]   gain_p;
        logic signed [GAIN_W-1:0]   gain_i;
        logic signed [GAIN_W-1:0]   gain_d;
        logic        [BASE_W-1:0]   base_speed;
        logic signed [TRIM_W-1:0]   right_trim;
        logic        [SETTLE_W-1:0] settle_ticks;
        logic        [TABLE_W-1:0]  error_table;
    } cfg_t;

    typedef struct packed {
        logic ld_b;
        logic ld_c;
        logic ld_d;
        logic ld_e;
    } pipe_ctl_t;

    function automatic int max2(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

    function automatic int sum_w(input int lim);
        return $clog2(lim + 1) + 1;
    endfunction

    function automatic int acc_w(input int sw);
        return max2(GAIN_W + ERR_W + 1, GAIN_W + sw) + 2;
    endfunction

    function automatic int pid_w(input int sw);
        return acc_w(sw) - FRAC_BITS;
    endfunction

    function automatic int spd_w(input int pw, input int duty);
        return max2(max2(pw, TRIM_W), $clog2(duty + 1) + 1) + 2;
    endfunction

endpackage

/* design/lfpd_if.sv */
// Handshake channels of the line-follower PID motor drive.
// Sensor channel in, duty channel out; widths come from lfpd_pkg.
interface lfpd_in_if;
    import lfpd_pkg::*;

    logic            valid;
    logic            ready;
    logic [IN_W-1:0] sensor_bits;

    modport source (output valid, output sensor_bits, input ready);
    modport sink (input valid, input sensor_bits, output ready);
endinterface

interface lfpd_out_if;
    import lfpd_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [DUTY_OUT_W-1:0] fwd_left;
    logic [DUTY_OUT_W-1:0] rev_left;
    logic [DUTY_OUT_W-1:0] fwd_right;
    logic [DUTY_OUT_W-1:0] rev_right;

    modport source (output valid, output fwd_left, output rev_left, output fwd_right,
                    output rev_right, input ready);
    modport sink (input valid, input fwd_left, input rev_left, input fwd_right,
                  input rev_right, output ready);
endinterface

/* design/lfpd_err.sv */
// Line error tracking: sensor hold, crossing count, error table lookup, integral.
// Holds all control state of the tick and the difference register of stage B.
// Depends on lfpd_pkg.
module lfpd_err #(
    parameter int SUM_LIMIT = lfpd_pkg::DEF_SUM_LIMIT
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  lfpd_pkg::pipe_ctl_t                       ctl,
    input  lfpd_pkg::cfg_t                            cfg,
    input  logic [lfpd_pkg::IN_W-1:0]                 sensor_bits,
    output logic signed [lfpd_pkg::ERR_W-1:0]         line_err,
    output logic signed [lfpd_pkg::sum_w(SUM_LIMIT)-1:0] err_sum,
    output logic signed [lfpd_pkg::ERR_W:0]           err_diff
);
    import lfpd_pkg::*;

    localparam int SUM_W = sum_w(SUM_LIMIT);
    localparam int SE_W  = max2(SUM_W, ERR_W) + 1;

    localparam logic signed [SE_W-1:0] LIM_HI = SE_W'(SUM_LIMIT);
    localparam logic signed [SE_W-1:0] LIM_LO = -LIM_HI;

    localparam logic [IN_W-1:0] PAT_NONE    = 4'h0;
    localparam logic [IN_W-1:0] PAT_OUTER_L = 4'h1;
    localparam logic [IN_W-1:0] PAT_INNER_L = 4'h2;
    localparam logic [IN_W-1:0] PAT_WIDE_L  = 4'h3;
    localparam logic [IN_W-1:0] PAT_INNER_R = 4'h4;
    localparam logic [IN_W-1:0] PAT_OUTER_R = 4'h8;
    localparam logic [IN_W-1:0] PAT_WIDE_R  = 4'hC;
    localparam logic [IN_W-1:0] PAT_ALL     = 4'hF;

    localparam int TBL_WIDE_L  = 0;
    localparam int TBL_WIDE_R  = 1;
    localparam int TBL_OUTER_L = 2;
    localparam int TBL_INNER_L = 3;
    localparam int TBL_INNER_R = 4;
    localparam int TBL_OUTER_R = 5;

    localparam logic [CNT_W-1:0] CROSS_LAST = 3'd3;
    localparam logic [CNT_W-1:0] CROSS_DONE = 3'd4;

    function automatic logic signed [ERR_W-1:0] tbl_entry(input logic [TABLE_W-1:0] tbl,
                                                          input int k);
        return signed'(tbl[k*ERR_W +: ERR_W]);
    endfunction

    logic        [IN_W-1:0]     held_reg;
    logic        [SETTLE_W-1:0] settle_reg;
    logic        [CNT_W-1:0]    cross_reg;
    logic signed [ERR_W-1:0]    err_reg;
    logic signed [SUM_W-1:0]    sum_reg;
    logic signed [ERR_W:0]      diff_reg;

    logic        [IN_W-1:0]     held_next;
    logic        [SETTLE_W-1:0] settle_next;
    logic        [CNT_W-1:0]    cross_next;
    logic signed [ERR_W-1:0]    err_next;
    logic signed [SUM_W-1:0]    sum_next;
    logic signed [SE_W-1:0]     sum_wide;
    logic signed [ERR_W-1:0]    t_inner_l;
    logic signed [ERR_W-1:0]    t_inner_r;

    always_comb
    begin
        t_inner_l   = tbl_entry(cfg.error_table, TBL_INNER_L);
        t_inner_r   = tbl_entry(cfg.error_table, TBL_INNER_R);
        held_next   = (settle_reg == '0) ? sensor_bits : held_reg;
        settle_next = (settle_reg == '0) ? '0 : settle_reg - SETTLE_W'(1);
        cross_next  = cross_reg;
        err_next    = err_reg;
        case (held_next)
            PAT_ALL:
            begin
                if (cross_reg < CROSS_LAST)
                begin
                    err_next    = '0;
                    cross_next  = cross_reg + CNT_W'(1);
                    settle_next = cfg.settle_ticks >> 2;
                end
                else if (cross_reg == CROSS_LAST)
                begin
                    err_next    = tbl_entry(cfg.error_table, TBL_WIDE_L);
                    cross_next  = CROSS_DONE;
                    settle_next = cfg.settle_ticks;
                end
            end
            PAT_WIDE_L:  err_next = tbl_entry(cfg.error_table, TBL_WIDE_L);
            PAT_WIDE_R:  err_next = tbl_entry(cfg.error_table, TBL_WIDE_R);
            PAT_OUTER_L: err_next = tbl_entry(cfg.error_table, TBL_OUTER_L);
            PAT_INNER_L: err_next = t_inner_l;
            PAT_INNER_R: err_next = t_inner_r;
            PAT_OUTER_R: err_next = tbl_entry(cfg.error_table, TBL_OUTER_R);
            PAT_NONE:
            begin
                if (!(err_reg < t_inner_l || err_reg > t_inner_r))
                begin
                    err_next = '0;
                end
            end
            default: ;
        endcase

        sum_wide = SE_W'(sum_reg) + SE_W'(err_next);
        if (sum_wide > LIM_HI)
        begin
            sum_next = SUM_W'(LIM_HI);
        end
        else if (sum_wide < LIM_LO)
        begin
            sum_next = SUM_W'(LIM_LO);
        end
        else
        begin
            sum_next = SUM_W'(sum_wide);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg   <= '0;
            settle_reg <= '0;
            cross_reg  <= '0;
            err_reg    <= '0;
            sum_reg    <= '0;
        end
        else if (ctl.ld_b)
        begin
            held_reg   <= held_next;
            settle_reg <= settle_next;
            cross_reg  <= cross_next;
            err_reg    <= err_next;
            sum_reg    <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.ld_b)
        begin
            diff_reg <= (ERR_W+1)'(err_next) - (ERR_W+1)'(err_reg);
        end
    end

    assign line_err = err_reg;
    assign err_sum  = sum_reg;
    assign err_diff = diff_reg;

endmodule

/* design/lfpd_pid.sv */
// PID term: three gain products in stage C, their sum scaled by 1/256 toward zero in D.
// Depends on lfpd_pkg.
module lfpd_pid #(
    parameter int SUM_LIMIT = lfpd_pkg::DEF_SUM_LIMIT
) (
    input  logic                                         clk,
    input  lfpd_pkg::pipe_ctl_t                          ctl,
    input  lfpd_pkg::cfg_t                               cfg,
    input  logic signed [lfpd_pkg::ERR_W-1:0]            line_err,
    input  logic signed [lfpd_pkg::sum_w(SUM_LIMIT)-1:0] err_sum,
    input  logic signed [lfpd_pkg::ERR_W:0]              err_diff,
    output logic signed [lfpd_pkg::pid_w(lfpd_pkg::sum_w(SUM_LIMIT))-1:0] pid
);
    import lfpd_pkg::*;

    localparam int SUM_W = sum_w(SUM_LIMIT);
    localparam int P_W   = GAIN_W + ERR_W;
    localparam int I_W   = GAIN_W + SUM_W;
    localparam int D_W   = GAIN_W + ERR_W + 1;
    localparam int ACC_W = acc_w(SUM_W);
    localparam int PID_W = pid_w(SUM_W);

    localparam logic signed [ACC_W-1:0] ROUND_ADD = ACC_W'((1 << FRAC_BITS) - 1);

    logic signed [P_W-1:0]   p_prod_reg;
    logic signed [I_W-1:0]   i_prod_reg;
    logic signed [D_W-1:0]   d_prod_reg;
    logic signed [PID_W-1:0] pid_reg;
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] acc_adj;

    always_ff @(posedge clk)
    begin
        if (ctl.ld_c)
        begin
            p_prod_reg <= P_W'(cfg.gain_p) * P_W'(line_err);
            i_prod_reg <= I_W'(cfg.gain_i) * I_W'(err_sum);
            d_prod_reg <= D_W'(cfg.gain_d) * D_W'(err_diff);
        end
    end

    always_comb
    begin
        acc     = ACC_W'(p_prod_reg) + ACC_W'(i_prod_reg) + ACC_W'(d_prod_reg);
        acc_adj = acc[ACC_W-1] ? acc + ROUND_ADD : acc;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.ld_d)
        begin
            pid_reg <= PID_W'(acc_adj >>> FRAC_BITS);
        end
    end

    assign pid = pid_reg;

endmodule

/* design/lfpd_drive.sv */
// Wheel speeds from base speed, PID term and right trim, clamped and split into
// forward and reverse duties in the output register (stage E). Depends on lfpd_pkg.
module lfpd_drive #(
    parameter int MAX_DUTY  = lfpd_pkg::DEF_MAX_DUTY,
    parameter int SUM_LIMIT = lfpd_pkg::DEF_SUM_LIMIT
) (
    input  logic                                   clk,
    input  lfpd_pkg::pipe_ctl_t                    ctl,
    input  lfpd_pkg::cfg_t                         cfg,
    input  logic signed [lfpd_pkg::pid_w(lfpd_pkg::sum_w(SUM_LIMIT))-1:0] pid,
    output logic [lfpd_pkg::DUTY_OUT_W-1:0]        fwd_left,
    output logic [lfpd_pkg::DUTY_OUT_W-1:0]        rev_left,
    output logic [lfpd_pkg::DUTY_OUT_W-1:0]        fwd_right,
    output logic [lfpd_pkg::DUTY_OUT_W-1:0]        rev_right
);
    import lfpd_pkg::*;

    localparam int PID_W = pid_w(sum_w(SUM_LIMIT));
    localparam int SPD_W = spd_w(PID_W, MAX_DUTY);

    localparam logic signed [SPD_W-1:0] DUTY_HI = SPD_W'(MAX_DUTY);
    localparam logic signed [SPD_W-1:0] DUTY_LO = -DUTY_HI;

    function automatic logic signed [SPD_W-1:0] clamp_duty(input logic signed [SPD_W-1:0] v);
        if (v > DUTY_HI)
        begin
            return DUTY_HI;
        end
        else if (v < DUTY_LO)
        begin
            return DUTY_LO;
        end
        return v;
    endfunction

    logic signed [SPD_W-1:0]      base_s;
    logic signed [SPD_W-1:0]      left_spd;
    logic signed [SPD_W-1:0]      right_spd;
    logic signed [SPD_W-1:0]      left_neg;
    logic signed [SPD_W-1:0]      right_neg;
    logic [DUTY_OUT_W-1:0]        fwd_left_reg;
    logic [DUTY_OUT_W-1:0]        rev_left_reg;
    logic [DUTY_OUT_W-1:0]        fwd_right_reg;
    logic [DUTY_OUT_W-1:0]        rev_right_reg;

    always_comb
    begin
        base_s    = SPD_W'(signed'({1'b0, cfg.base_speed}));
        left_spd  = clamp_duty(base_s - SPD_W'(pid));
        right_spd = clamp_duty(base_s + SPD_W'(pid) - SPD_W'(cfg.right_trim));
        left_neg  = -left_spd;
        right_neg = -right_spd;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.ld_e)
        begin
            fwd_left_reg  <= left_spd[SPD_W-1] ? '0 : left_spd[DUTY_OUT_W-1:0];
            rev_left_reg  <= left_spd[SPD_W-1] ? left_neg[DUTY_OUT_W-1:0] : '0;
            fwd_right_reg <= right_spd[SPD_W-1] ? '0 : right_spd[DUTY_OUT_W-1:0];
            rev_right_reg <= right_spd[SPD_W-1] ? right_neg[DUTY_OUT_W-1:0] : '0;
        end
    end

    assign fwd_left  = fwd_left_reg;
    assign rev_left  = rev_left_reg;
    assign fwd_right = fwd_right_reg;
    assign rev_right = rev_right_reg;

endmodule

/* design/line_follow_pid_motor_drive.sv */
// Top level of the line-follower PID motor drive: configuration registers,
// input register, pipeline valid and ready control. Depends on lfpd_pkg,
// lfpd_if, lfpd_err, lfpd_pid and lfpd_drive.
//
// One beat on sensor_in carries the four line-sensor bits of one control tick.
// Each tick yields exactly one beat on drive_out with the forward and reverse
// duty compare values of both wheels. The configuration port writes one register
// per cycle while cfg_wr_en is high. Use it only while no tick is in flight; the block does not check this.
//
// The datapath is a five-stage pipeline: input register, error and integral
// update, gain products, scaled PID sum, and the output register. A sensor beat
// passes through these stages in that order before its result appears on
// drive_out, and one tick is accepted every cycle while drive_out is not stalled.
// The error state is updated once per tick, so consecutive ticks follow without a gap.
//
// When drive_out is stalled, each stage keeps its beat and the pipeline fills;
// sensor_in.ready drops only once all five stages hold a beat. Reset clears all
// pipeline valid bits, the control state and the config registers to their defaults.
module line_follow_pid_motor_drive #(
    parameter int MAX_DUTY  = lfpd_pkg::DEF_MAX_DUTY,
    parameter int SUM_LIMIT = lfpd_pkg::DEF_SUM_LIMIT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [lfpd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lfpd_pkg::CFG_DATA_W-1:0]   cfg_data,
    lfpd_in_if.sink                           sensor_in,
    lfpd_out_if.source                        drive_out
);
    import lfpd_pkg::*;

    localparam int SUM_W = sum_w(SUM_LIMIT);
    localparam int PID_W = pid_w(SUM_W);

    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BASE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TRIM   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SETTLE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TABLE  = 3'd6;

    cfg_t                    cfg_reg;
    logic [IN_W-1:0]         sensor_reg;
    logic                    va_reg;
    logic                    vb_reg;
    logic                    vc_reg;
    logic                    vd_reg;
    logic                    ve_reg;
    logic                    va_next;
    logic                    vb_next;
    logic                    vc_next;
    logic                    vd_next;
    logic                    ve_next;
    logic                    rdy_a;
    logic                    rdy_b;
    logic                    rdy_c;
    logic                    rdy_d;
    logic                    rdy_e;
    logic                    ld_a;
    pipe_ctl_t               ctl;
    logic signed [ERR_W-1:0] line_err;
    logic signed [SUM_W-1:0] err_sum;
    logic signed [ERR_W:0]   err_diff;
    logic signed [PID_W-1:0] pid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_p       <= RST_GAIN_P;
            cfg_reg.gain_i       <= RST_GAIN_I;
            cfg_reg.gain_d       <= RST_GAIN_D;
            cfg_reg.base_speed   <= RST_BASE;
            cfg_reg.right_trim   <= RST_TRIM;
            cfg_reg.settle_ticks <= RST_SETTLE;
            cfg_reg.error_table  <= RST_TABLE;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_GAIN_P: cfg_reg.gain_p       <= signed'(cfg_data[GAIN_W-1:0]);
                REG_GAIN_I: cfg_reg.gain_i       <= signed'(cfg_data[GAIN_W-1:0]);
                REG_GAIN_D: cfg_reg.gain_d       <= signed'(cfg_data[GAIN_W-1:0]);
                REG_BASE:   cfg_reg.base_speed   <= cfg_data[BASE_W-1:0];
                REG_TRIM:   cfg_reg.right_trim   <= signed'(cfg_data[TRIM_W-1:0]);
                REG_SETTLE: cfg_reg.settle_ticks <= cfg_data[SETTLE_W-1:0];
                REG_TABLE:  cfg_reg.error_table  <= cfg_data[TABLE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        rdy_e = !ve_reg || drive_out.ready;
        rdy_d = !vd_reg || rdy_e;
        rdy_c = !vc_reg || rdy_d;
        rdy_b = !vb_reg || rdy_c;
        rdy_a = !va_reg || rdy_b;

        ld_a     = sensor_in.valid && rdy_a;
        ctl.ld_b = va_reg && rdy_b;
        ctl.ld_c = vb_reg && rdy_c;
        ctl.ld_d = vc_reg && rdy_d;
        ctl.ld_e = vd_reg && rdy_e;

        va_next = ld_a     || (va_reg && !ctl.ld_b);
        vb_next = ctl.ld_b || (vb_reg && !ctl.ld_c);
        vc_next = ctl.ld_c || (vc_reg && !ctl.ld_d);
        vd_next = ctl.ld_d || (vd_reg && !ctl.ld_e);
        ve_next = ctl.ld_e || (ve_reg && !drive_out.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
            ve_reg <= 1'b0;
        end
        else
        begin
            va_reg <= va_next;
            vb_reg <= vb_next;
            vc_reg <= vc_next;
            vd_reg <= vd_next;
            ve_reg <= ve_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld_a)
        begin
            sensor_reg <= sensor_in.sensor_bits;
        end
    end

    assign sensor_in.ready = rdy_a;
    assign drive_out.valid = ve_reg;

    lfpd_err #(
        .SUM_LIMIT (SUM_LIMIT)
    ) u_err (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .cfg         (cfg_reg),
        .sensor_bits (sensor_reg),
        .line_err    (line_err),
        .err_sum     (err_sum),
        .err_diff    (err_diff)
    );

    lfpd_pid #(
        .SUM_LIMIT (SUM_LIMIT)
    ) u_pid (
        .clk      (clk),
        .ctl      (ctl),
        .cfg      (cfg_reg),
        .line_err (line_err),
        .err_sum  (err_sum),
        .err_diff (err_diff),
        .pid      (pid)
    );

    lfpd_drive #(
        .MAX_DUTY  (MAX_DUTY),
        .SUM_LIMIT (SUM_LIMIT)
    ) u_drive (
        .clk       (clk),
        .ctl       (ctl),
        .cfg       (cfg_reg),
        .pid       (pid),
        .fwd_left  (drive_out.fwd_left),
        .rev_left  (drive_out.rev_left),
        .fwd_right (drive_out.fwd_right),
        .rev_right (drive_out.rev_right)
    );

endmodule

/* design/lfpd_check.sv */
// Port-level checks of the line-follower PID motor drive and their bind.
// Depends on lfpd_pkg and on the top level line_follow_pid_motor_drive.
module lfpd_check #(
    parameter int MAX_DUTY = lfpd_pkg::DEF_MAX_DUTY
) (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_ready,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic [lfpd_pkg::DUTY_OUT_W-1:0] fwd_left,
    input logic [lfpd_pkg::DUTY_OUT_W-1:0] rev_left,
    input logic [lfpd_pkg::DUTY_OUT_W-1:0] fwd_right,
    input logic [lfpd_pkg::DUTY_OUT_W-1:0] rev_right
);
    import lfpd_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(fwd_left) && $stable(rev_left)
            && $stable(fwd_right) && $stable(rev_right))
        else $error("Stalled output beat changed.");

    a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("Output beat offered during reset.");

    a_one_dir: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (fwd_left == '0 || rev_left == '0) && (fwd_right == '0 || rev_right == '0))
        else $error("Wheel driven forward and reverse at once.");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> int'(fwd_left) <= MAX_DUTY && int'(rev_left) <= MAX_DUTY
            && int'(fwd_right) <= MAX_DUTY && int'(rev_right) <= MAX_DUTY)
        else $error("Duty beyond the limit.");

    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid || out_ready |-> in_ready)
        else $error("Input stalled while the output is free.");

endmodule

bind line_follow_pid_motor_drive lfpd_check #(
    .MAX_DUTY (MAX_DUTY)
) u_lfpd_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (sensor_in.ready),
    .out_valid (drive_out.valid),
    .out_ready (drive_out.ready),
    .fwd_left  (drive_out.fwd_left),
    .rev_left  (drive_out.rev_left),
    .fwd_right (drive_out.fwd_right),
    .rev_right (drive_out.rev_right)
);
